// File: hdl/i2a_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for the integer-to-ASCII formatter
// Radix codes, character codes, run layout struct and the digit-to-ASCII map.
// ----------------------------------------------------------------------------
package i2a_pkg;

	localparam int DEF_MAX_WIDTH   = 40;
	localparam int DEF_DIGIT_SLOTS = 22;

	localparam int VALUE_W    = 64;
	localparam int HEX_DIGITS = 16;
	localparam int OCT_DIGITS = 22;
	localparam int BCD_DIGITS = 20;
	localparam int DAB_BITS   = 2;    // binary bits consumed per conversion cycle

	// run counters cover MAX_WIDTH + DIGIT_SLOTS + 1 at the default parameters
	localparam int CNT_W = 7;

	localparam logic [1:0] RADIX_OCT  = 2'd0;
	localparam logic [1:0] RADIX_DEC  = 2'd1;
	localparam logic [1:0] RADIX_HEX  = 2'd2;
	localparam logic [1:0] RADIX_NONE = 2'd3;

	localparam logic [6:0] CHAR_SPACE = 7'h20;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_UPPER_BASE = 7'h37;   // 'A' - 10
	localparam logic [6:0] CHAR_LOWER_BASE = 7'h57;   // 'a' - 10

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_NORM,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [CNT_W-1:0] spaces;
		logic             sign;
		logic [CNT_W-1:0] zeros;
		logic [CNT_W-1:0] digits;
	} layout_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] base;
		if (d < 4'd10) begin
			base = CHAR_ZERO;
		end else if (upper) begin
			base = CHAR_UPPER_BASE;
		end else begin
			base = CHAR_LOWER_BASE;
		end
		return base + {3'b000, d};
	endfunction

endpackage
`default_nettype wire

// File: hdl/i2a_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_if: valid/ready channels of the integer-to-ASCII formatter
// Number channel (magnitude plus format controls) and character channel.
// ----------------------------------------------------------------------------
interface i2a_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] value;
	logic [1:0]  radix;
	logic        uppercase;
	logic        negative;
	logic [5:0]  field_width;
	logic        has_precision;
	logic [5:0]  precision_digits;
	logic        zero_fill;

	modport source (
		output valid, value, radix, uppercase, negative, field_width,
		       has_precision, precision_digits, zero_fill,
		input  ready
	);
	modport sink (
		input  valid, value, radix, uppercase, negative, field_width,
		       has_precision, precision_digits, zero_fill,
		output ready
	);
endinterface

interface i2a_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] char_code;
	logic       last;

	modport source (output valid, char_code, last, input ready);
	modport sink (input valid, char_code, last, output ready);
endinterface
`default_nettype wire

// File: hdl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: octal and hex load the digit register in the accept cycle; decimal first runs the
//   two-bit BCD steps in i2a_dabble and loads the digits on its done pulse. Leading zeros
//   are then stripped one digit at a time (up to DIGIT_SLOTS-1) before the sequencer starts.
// Throughput: one character per cycle while the sink is ready; a new number is taken once
//   the FSM is back in idle, after the last character of the run enters the output register.
// Reset: asynchronous, clears the control FSM, counters and output valid; no memory to clear.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: printf-style %o / %u / %x conversion
// Converts a 64-bit magnitude to a padded ASCII run, one character per transaction.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter import i2a_pkg::*; #(
	parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
	parameter int DIGIT_SLOTS = DEF_DIGIT_SLOTS
) (
	input  logic      clk,
	input  logic      arst_n,
	i2a_in_if.sink    num,
	i2a_out_if.source text
);

	state_t state_q, state_d;

	logic [3:0]       digits_q [DIGIT_SLOTS];
	logic [CNT_W-1:0] count_q;
	logic             upper_q;
	logic             neg_q;
	logic             has_prec_q;
	logic             zfill_q;
	logic [5:0]       width_q;
	logic [5:0]       prec_q;

	logic accept;
	logic special;
	logic radix_ok;
	logic dab_start;
	logic dab_done;
	logic norm_shift;
	logic emit_start;
	logic emit_busy;
	logic digit_take;
	logic [5:0] width_sat;
	logic [5:0] prec_sat;

	logic [BCD_DIGITS*4-1:0] bcd;
	logic [VALUE_W+1:0]      value_ext;
	logic [3:0]              ld_hex [DIGIT_SLOTS];
	logic [3:0]              ld_oct [DIGIT_SLOTS];
	logic [3:0]              ld_dec [DIGIT_SLOTS];

	logic [CNT_W-1:0] zeros;
	logic [CNT_W-1:0] content;
	logic [CNT_W-1:0] spaces;
	layout_t          layout;

	assign accept    = num.valid && num.ready;
	assign special   = num.has_precision && (num.precision_digits == 6'd0) &&
	                   (num.value == '0);
	assign radix_ok  = (num.radix != RADIX_NONE);
	assign width_sat = (num.field_width > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : num.field_width;
	assign prec_sat  = (num.precision_digits > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) :
	                   num.precision_digits;
	assign value_ext = {2'b00, num.value};

	// digit register images, least significant digit in slot 0
	for (genvar g = 0; g < DIGIT_SLOTS; g++) begin : g_load
		if (g < HEX_DIGITS) begin : g_hex
			assign ld_hex[g] = num.value[4*g +: 4];
		end else begin : g_hex_pad
			assign ld_hex[g] = 4'd0;
		end
		if (g < OCT_DIGITS) begin : g_oct
			assign ld_oct[g] = {1'b0, value_ext[3*g +: 3]};
		end else begin : g_oct_pad
			assign ld_oct[g] = 4'd0;
		end
		if (g < BCD_DIGITS) begin : g_dec
			assign ld_dec[g] = bcd[4*g +: 4];
		end else begin : g_dec_pad
			assign ld_dec[g] = 4'd0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && radix_ok) begin
					if (num.radix == RADIX_DEC && !special) begin
						state_d = ST_CONV;
					end else begin
						state_d = ST_NORM;
					end
				end
			end
			ST_CONV: begin
				if (dab_done) begin
					state_d = ST_NORM;
				end
			end
			ST_NORM: begin
				if (!norm_shift) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!emit_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		num.ready  = (state_q == ST_IDLE);
		dab_start  = accept && (num.radix == RADIX_DEC) && !special;
		norm_shift = (state_q == ST_NORM) && (count_q > CNT_W'(1)) &&
		             (digits_q[DIGIT_SLOTS-1] == 4'd0);
		emit_start = (state_q == ST_NORM) && !norm_shift;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= special ? '0 : CNT_W'(DIGIT_SLOTS);
			end else if (norm_shift) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			upper_q    <= num.uppercase;
			neg_q      <= num.negative;
			has_prec_q <= num.has_precision;
			zfill_q    <= num.zero_fill;
			width_q    <= width_sat;
			prec_q     <= prec_sat;
			if (num.radix == RADIX_HEX) begin
				digits_q <= ld_hex;
			end else begin
				digits_q <= ld_oct;
			end
		end else if (state_q == ST_CONV && dab_done) begin
			digits_q <= ld_dec;
		end else if (norm_shift || digit_take) begin
			for (int k = DIGIT_SLOTS - 1; k > 0; k--) begin
				digits_q[k] <= digits_q[k-1];
			end
			digits_q[0] <= 4'd0;
		end
	end

	// run layout from the final digit count
	always_comb begin
		zeros   = (has_prec_q && CNT_W'(prec_q) > count_q) ? CNT_W'(prec_q) - count_q : '0;
		content = count_q + zeros + CNT_W'(neg_q);
		spaces  = (CNT_W'(width_q) > content) ? CNT_W'(width_q) - content : '0;
		if (zfill_q && !has_prec_q) begin
			zeros  = spaces;
			spaces = '0;
		end
		layout.spaces = spaces;
		layout.sign   = neg_q;
		layout.zeros  = zeros;
		layout.digits = count_q;
	end

	i2a_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dab_start),
		.value  (num.value),
		.done   (dab_done),
		.bcd    (bcd)
	);

	i2a_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (emit_start),
		.layout     (layout),
		.top_digit  (digits_q[DIGIT_SLOTS-1]),
		.upper      (upper_q),
		.busy       (emit_busy),
		.digit_take (digit_take),
		.text       (text)
	);

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !emit_busy)
		else $error("sequencer busy while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DIGIT_SLOTS))
		else $error("digit count beyond slot count");

	a_take_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		digit_take |-> (state_q == ST_EMIT))
		else $error("digit consumed outside emit phase");

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		emit_start |-> !emit_busy)
		else $error("sequencer restarted while busy");

endmodule
`default_nettype wire

// File: hdl/i2a_dabble.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_dabble: serial binary-to-BCD converter
// Shift-and-add-3 over the 64-bit magnitude, two bits per cycle.
// ----------------------------------------------------------------------------
module i2a_dabble import i2a_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_W-1:0]      value,
	output logic                    done,
	output logic [BCD_DIGITS*4-1:0] bcd
);

	localparam int STEPS  = VALUE_W / DAB_BITS;
	localparam int STEP_W = $clog2(STEPS);

	logic [VALUE_W-1:0]      bin_q;
	logic [BCD_DIGITS*4-1:0] bcd_q;
	logic [STEP_W-1:0]       step_q;
	logic                    busy_q;
	logic                    done_q;

	logic [VALUE_W-1:0]      bin_d;
	logic [BCD_DIGITS*4-1:0] bcd_d;

	always_comb begin
		bin_d = bin_q;
		bcd_d = bcd_q;
		for (int s = 0; s < DAB_BITS; s++) begin
			for (int k = 0; k < BCD_DIGITS; k++) begin
				if (bcd_d[4*k +: 4] >= 4'd5) begin
					bcd_d[4*k +: 4] = bcd_d[4*k +: 4] + 4'd3;
				end
			end
			bcd_d = {bcd_d[BCD_DIGITS*4-2:0], bin_d[VALUE_W-1]};
			bin_d = {bin_d[VALUE_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= bin_d;
			bcd_q <= bcd_d;
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule
`default_nettype wire

// File: hdl/i2a_emit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2a_emit: character sequencer
// Counts out spaces, sign, zeros and digits, one character per cycle while the
// sink is ready, into a registered output stage.
// ----------------------------------------------------------------------------
module i2a_emit import i2a_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  layout_t    layout,
	input  logic [3:0] top_digit,
	input  logic       upper,
	output logic       busy,
	output logic       digit_take,
	i2a_out_if.source  text
);

	logic [CNT_W-1:0] sp_q;
	logic             sign_q;
	logic [CNT_W-1:0] zr_q;
	logic [CNT_W-1:0] dg_q;
	logic             out_valid_q;
	logic [6:0]       char_q;
	logic             last_q;

	logic [CNT_W-1:0] remaining;
	logic             adv;
	logic [6:0]       char_d;

	always_comb begin
		remaining  = sp_q + zr_q + dg_q + CNT_W'(sign_q);
		busy       = (remaining != '0);
		adv        = busy && (!out_valid_q || text.ready);
		digit_take = 1'b0;
		if (sp_q != '0) begin
			char_d = CHAR_SPACE;
		end else if (sign_q) begin
			char_d = CHAR_MINUS;
		end else if (zr_q != '0) begin
			char_d = CHAR_ZERO;
		end else begin
			char_d     = digit_char(top_digit, upper);
			digit_take = adv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			sign_q      <= 1'b0;
			zr_q        <= '0;
			dg_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				sp_q   <= layout.spaces;
				sign_q <= layout.sign;
				zr_q   <= layout.zeros;
				dg_q   <= layout.digits;
			end else if (adv) begin
				if (sp_q != '0) begin
					sp_q <= sp_q - 1'b1;
				end else if (sign_q) begin
					sign_q <= 1'b0;
				end else if (zr_q != '0) begin
					zr_q <= zr_q - 1'b1;
				end else begin
					dg_q <= dg_q - 1'b1;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			char_q <= char_d;
			last_q <= (remaining == CNT_W'(1));
		end
	end

	assign text.valid     = out_valid_q;
	assign text.char_code = char_q;
	assign text.last      = last_q;

endmodule
`default_nettype wire

// File: tb/i2a_text_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_text_scoreboard: character-stream check for the integer-to-ASCII formatter
// Watches the number and character channels. Each accepted number is formatted
// into its expected character run. Each accepted character is compared with
// the oldest expected one.
// ----------------------------------------------------------------------------
module i2a_text_scoreboard import i2a_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	i2a_in_if     num,
	i2a_out_if    text,
	output int    mismatches,
	output int    pending
);

	localparam int MAX_WIDTH   = DEF_MAX_WIDTH;
	localparam int DIGIT_SLOTS = DEF_DIGIT_SLOTS;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last;
	} text_char_t;

	text_char_t expected_chars[$];
	int         error_count = 0;
	int         queued = 0;

	assign mismatches = error_count;
	assign pending    = queued;

	task automatic report_mismatch(input string msg);
		$display("ERROR t=%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic text_char_t mk_char(input logic [6:0] code);
		text_char_t c;
		c.char_code = code;
		c.last      = 1'b0;
		return c;
	endfunction

	// Appends the characters of one formatted number to the expected stream.
	function automatic void format_number(
		input logic [63:0] value,
		input logic [1:0]  radix,
		input logic        upper,
		input logic        neg,
		input logic [5:0]  fw,
		input logic        hp,
		input logic [5:0]  pd,
		input logic        zf
	);
		logic [6:0]  digit_q[$];
		logic [63:0] v;
		logic [63:0] base;
		logic [3:0]  d;
		int unsigned w, p, count, zeros, content, spaces, i;
		int          start;

		case (radix)
			RADIX_OCT: base = 64'd8;
			RADIX_DEC: base = 64'd10;
			RADIX_HEX: base = 64'd16;
			default:   return;
		endcase
		w = (fw > MAX_WIDTH) ? MAX_WIDTH : fw;
		p = (pd > MAX_WIDTH) ? MAX_WIDTH : pd;

		// explicit zero precision on a zero value prints no digit at all
		if (!(hp && p == 0 && value == 64'd0)) begin
			v = value;
			do begin
				d = 4'(v % base);
				if (d < 4'd10) begin
					digit_q.push_front(CHAR_ZERO + {3'b000, d});
				end else begin
					digit_q.push_front((upper ? CHAR_UPPER_BASE : CHAR_LOWER_BASE) + {3'b000, d});
				end
				v = v / base;
			end while (v != 64'd0 && digit_q.size() < DIGIT_SLOTS);
		end

		count   = digit_q.size();
		zeros   = (hp && p > count) ? p - count : 0;
		content = count + zeros + (neg ? 1 : 0);
		spaces  = (w > content) ? w - content : 0;
		if (zf && !hp) begin
			zeros  += spaces;
			spaces  = 0;
		end

		start = expected_chars.size();
		for (i = 0; i < spaces; i++) expected_chars.push_back(mk_char(CHAR_SPACE));
		if (neg) expected_chars.push_back(mk_char(CHAR_MINUS));
		for (i = 0; i < zeros; i++) expected_chars.push_back(mk_char(CHAR_ZERO));
		for (i = 0; i < count; i++) expected_chars.push_back(mk_char(digit_q[i]));
		if (expected_chars.size() > start) begin
			expected_chars[expected_chars.size() - 1].last = 1'b1;
		end
	endfunction

	always @(posedge clk) begin
		text_char_t exp_char;
		if (arst_n) begin
			if (text.valid && text.ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("character 0x%h last=%b with none pending",
						text.char_code, text.last));
				end else begin
					exp_char = expected_chars.pop_front();
					if (text.char_code !== exp_char.char_code) begin
						report_mismatch($sformatf("char_code got 0x%h exp 0x%h",
							text.char_code, exp_char.char_code));
					end
					if (text.last !== exp_char.last) begin
						report_mismatch($sformatf("last got %b exp %b on char 0x%h",
							text.last, exp_char.last, exp_char.char_code));
					end
				end
			end
			if (num.valid && num.ready) begin
				format_number(num.value, num.radix, num.uppercase, num.negative,
					num.field_width, num.has_precision, num.precision_digits, num.zero_fill);
			end
			queued = expected_chars.size();
		end
	end

endmodule

// File: tb/integer_to_ascii_formatter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_test: top-level bench for the ASCII formatter
// Sends directed corner numbers, then random numbers in all radices, with
// random gaps on the number side and random stalls on the character side.
// A scoreboard beside the block predicts and checks every character.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_test;
	import i2a_pkg::*;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          RANDOM_NUMBERS = 437;

	typedef struct {
		logic [63:0] value;
		logic [1:0]  radix;
		logic        uppercase;
		logic        negative;
		logic [5:0]  field_width;
		logic        has_precision;
		logic [5:0]  precision_digits;
		logic        zero_fill;
	} num_item_t;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   pending;
	bit   src_burst = 1'b0;
	bit   snk_burst = 1'b0;

	i2a_in_if  num_ch ();
	i2a_out_if text_ch ();

	integer_to_ascii_formatter u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.text   (text_ch)
	);

	i2a_text_scoreboard u_scoreboard (
		.clk        (clk),
		.arst_n     (arst_n),
		.num        (num_ch),
		.text       (text_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic num_item_t mk(
		input logic [63:0] value,
		input logic [1:0]  radix,
		input logic        upper,
		input logic        neg,
		input logic [5:0]  fw,
		input logic        hp,
		input logic [5:0]  pd,
		input logic        zf
	);
		num_item_t it;
		it.value            = value;
		it.radix            = radix;
		it.uppercase        = upper;
		it.negative         = neg;
		it.field_width      = fw;
		it.has_precision    = hp;
		it.precision_digits = pd;
		it.zero_fill        = zf;
		return it;
	endfunction

	function automatic num_item_t random_number();
		num_item_t it;
		case ($urandom_range(0, 5))
			0: it.value = {$urandom, $urandom};
			1: it.value = {$urandom, $urandom} >> $urandom_range(0, 63);
			2: it.value = 64'($urandom_range(0, 20));
			3: it.value = ALL_ONES >> $urandom_range(0, 63);
			4: it.value = 64'd0;
			default: it.value = 64'd1 << $urandom_range(0, 63);
		endcase
		// unused radix now and then; otherwise one of the three bases
		it.radix = ($urandom_range(0, 19) == 0) ? RADIX_NONE : 2'($urandom_range(0, 2));
		it.uppercase        = 1'($urandom);
		it.negative         = 1'($urandom);
		it.field_width      = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
		                                                 : 6'($urandom_range(0, 30));
		it.has_precision    = 1'($urandom);
		it.precision_digits = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
		                                                 : 6'($urandom_range(0, 24));
		it.zero_fill        = 1'($urandom);
		return it;
	endfunction

	// Entered and left at a falling edge; valid stays high across back-to-back numbers.
	task automatic send_number(input num_item_t it);
		int gap;
		if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
		gap = src_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			num_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		num_ch.value            <= it.value;
		num_ch.radix            <= it.radix;
		num_ch.uppercase        <= it.uppercase;
		num_ch.negative         <= it.negative;
		num_ch.field_width      <= it.field_width;
		num_ch.has_precision    <= it.has_precision;
		num_ch.precision_digits <= it.precision_digits;
		num_ch.zero_fill        <= it.zero_fill;
		num_ch.valid            <= 1'b1;
		do @(posedge clk); while (!num_ch.ready);
		@(negedge clk);
	endtask

	// character side: random stall after each accepted transaction
	initial begin
		int gap;
		text_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		text_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (text_ch.valid && text_ch.ready) begin
				if ($urandom_range(0, 39) == 0) snk_burst = !snk_burst;
				gap = snk_burst ? 0 : $urandom_range(0, 19);
				if (gap != 0) begin
					@(negedge clk);
					text_ch.ready <= 1'b0;
					repeat (gap) @(negedge clk);
					text_ch.ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		num_item_t it;
		int        sent;
		arst_n                  = 1'b0;
		num_ch.valid            = 1'b0;
		num_ch.value            = '0;
		num_ch.radix            = RADIX_OCT;
		num_ch.uppercase        = 1'b0;
		num_ch.negative         = 1'b0;
		num_ch.field_width      = '0;
		num_ch.has_precision    = 1'b0;
		num_ch.precision_digits = '0;
		num_ch.zero_fill        = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// corners: zero and full-scale in each base, saturation, sign and fill rules
		send_number(mk(64'd0, RADIX_OCT, 0, 0, 0, 0, 0, 0));
		send_number(mk(64'd0, RADIX_DEC, 0, 0, 0, 0, 0, 0));
		send_number(mk(64'd0, RADIX_HEX, 1, 0, 0, 0, 0, 0));
		send_number(mk(ALL_ONES, RADIX_OCT, 0, 0, 0, 0, 0, 0));
		send_number(mk(ALL_ONES, RADIX_DEC, 0, 0, 0, 0, 0, 0));
		send_number(mk(ALL_ONES, RADIX_HEX, 0, 0, 0, 0, 0, 0));
		send_number(mk(ALL_ONES, RADIX_HEX, 1, 0, 0, 0, 0, 0));
		send_number(mk(64'hDEAD_BEEF_CAFE_F00D, RADIX_HEX, 1, 1, 40, 0, 0, 1));
		send_number(mk(64'd12345, RADIX_NONE, 0, 1, 20, 1, 5, 0));
		send_number(mk(64'd0, RADIX_DEC, 0, 0, 0, 1, 0, 0));
		send_number(mk(64'd0, RADIX_DEC, 0, 0, 5, 1, 0, 0));
		send_number(mk(64'd0, RADIX_DEC, 0, 1, 0, 0, 0, 0));
		send_number(mk(64'd0, RADIX_OCT, 0, 1, 0, 1, 0, 0));
		send_number(mk(64'd12345, RADIX_DEC, 0, 0, 63, 0, 0, 0));
		send_number(mk(64'd777, RADIX_OCT, 0, 1, 63, 1, 63, 0));
		send_number(mk(64'd42, RADIX_DEC, 0, 1, 10, 0, 0, 1));
		send_number(mk(64'd42, RADIX_DEC, 0, 1, 10, 1, 5, 1));
		send_number(mk(64'd123456, RADIX_DEC, 0, 0, 3, 1, 2, 0));
		send_number(mk(64'hABC, RADIX_HEX, 0, 0, 8, 0, 0, 0));
		send_number(mk(ALL_ONES, RADIX_OCT, 0, 1, 40, 0, 0, 1));
		send_number(mk(64'd1, RADIX_HEX, 1, 0, 40, 1, 40, 1));
		send_number(mk(64'd0, RADIX_HEX, 0, 0, 6, 1, 0, 1));
		send_number(mk(64'd9, RADIX_DEC, 1, 1, 63, 0, 63, 1));

		sent = 0;
		while (sent < RANDOM_NUMBERS) begin
			it = random_number();
			send_number(it);
			sent++;
		end
		num_ch.valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		// room for a stray character after the last expected one
		repeat (100) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
